// ===== hdl/pfu_pkg.sv =====
// ----------------------------------------------------------------------------
// pfu_pkg
// Shared types, constants and the grey ramp for the palette pixel unpacker.
// ----------------------------------------------------------------------------
package pfu_pkg;

   localparam int HEADER_BYTES    = 32;
   localparam int PALETTE_ENTRIES = 16;
   localparam int HPOS_WIDTH      = $clog2(HEADER_BYTES) + 1;
   localparam int PAL_IDX_WIDTH   = $clog2(PALETTE_ENTRIES);
   localparam int PAL_WIDTH       = 4;
   localparam int COUNT_WIDTH     = 13;
   localparam int CSR_IDX_WIDTH   = 1;
   localparam int DIGIT_CNT_WIDTH = 4;

   // Depth codes as carried in header byte 1 bits 5:4
   localparam logic [1:0] DEPTH_1BPP = 2'd0;
   localparam logic [1:0] DEPTH_2BPP = 2'd1;
   localparam logic [1:0] DEPTH_4BPP = 2'd2;
   localparam logic [1:0] DEPTH_8BPP = 2'd3;

   // Register indexes
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_LINE_PIXELS = 1'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_FRAME_ROWS  = 1'd1;

   localparam logic [COUNT_WIDTH-1:0] LINE_PIXELS_RESET = 13'd640;
   localparam logic [COUNT_WIDTH-1:0] FRAME_ROWS_RESET  = 13'd240;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       frame_start;
   } req_type;

   typedef struct packed {
      logic [31:0] pixel_argb;
      logic        last_of_byte;
      logic        line_end;
      logic        frame_end;
   } rsp_type;

   typedef struct packed {
      logic line_end;
      logic frame_end;
   } raster_flags_type;

   // Inverted 16-level grey ramp: level 0 is the brightest entry.
   function automatic logic [31:0] grey_argb(input logic [PAL_WIDTH-1:0] level);
      logic [31:0] argb;
      case (level)
         4'd0:    argb = 32'hFF88AA99;
         4'd1:    argb = 32'hFF7E9E8E;
         4'd2:    argb = 32'hFF759384;
         4'd3:    argb = 32'hFF6C887A;
         4'd4:    argb = 32'hFF637C70;
         4'd5:    argb = 32'hFF5A7166;
         4'd6:    argb = 32'hFF51665B;
         4'd7:    argb = 32'hFF485A51;
         4'd8:    argb = 32'hFF3F4F47;
         4'd9:    argb = 32'hFF36443D;
         4'd10:   argb = 32'hFF2D3833;
         4'd11:   argb = 32'hFF242D28;
         4'd12:   argb = 32'hFF1B221E;
         4'd13:   argb = 32'hFF121614;
         4'd14:   argb = 32'hFF090B0A;
         default: argb = 32'hFF000000;
      endcase
      return argb;
   endfunction

endpackage

// ===== hdl/palettized_framebuffer_pixel_unpacker.sv =====
// ----------------------------------------------------------------------------
// palettized_framebuffer_pixel_unpacker
// Expands packed palette framebuffer bytes into 32-bit ARGB grey pixels.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries framebuffer bytes in memory order; frame_start marks header
//   byte 0. The 32 header bytes load the depth code and the 16-entry palette
//   and give no pixels. Each later byte yields up to 8, 4 or 2 pixels on rsp_*
//   (1, 2 or 4 bpp), each with last-of-byte, line-end and frame-end flags.
//   csr_* writes line_pixels and frame_rows; write only while idle.
// Flow:
//   A header byte leaves the input ready. A pixel byte is shifted out one
//   digit per cycle through the unpack shift register while the output
//   register is free; no new byte is taken until its last pixel is emitted.
//   Each pixel goes from the shift register into the output register.
// Stalls:
//   When rsp_ready is low the current pixel holds in the output register
//   and the shifter stops; req_ready stays low until the byte is finished.
// Reset:
//   Clears the frame state, sets 2 bpp and the register defaults; the
//   palette holds garbage until the next header rewrites it.
// ----------------------------------------------------------------------------
module palettized_framebuffer_pixel_unpacker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  pfu_pkg::req_type                     req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output pfu_pkg::rsp_type                     rsp_data,
   input  logic                                 csr_write_enable,
   input  logic [pfu_pkg::CSR_IDX_WIDTH-1:0]    csr_index,
   input  logic [pfu_pkg::COUNT_WIDTH-1:0]      csr_write_data
);

   logic [pfu_pkg::COUNT_WIDTH-1:0]   line_pixels_ff, frame_rows_ff;
   logic                              frame_active_ff, frame_active_in;
   logic [pfu_pkg::HPOS_WIDTH-1:0]    hpos_ff, hpos_in;
   logic [1:0]                        depth_ff, depth_in;
   logic                              busy_ff, busy_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   pfu_pkg::rsp_type                  rsp_data_ff, rsp_data_in;
   logic [pfu_pkg::PAL_WIDTH-1:0]     palette_ff [pfu_pkg::PALETTE_ENTRIES];

   logic                              accept, active_now, in_header, load_pixels;
   logic                              slot_free, emit, done;
   logic [pfu_pkg::PAL_IDX_WIDTH-1:0] pixel_index;
   logic                              last_digit;
   pfu_pkg::raster_flags_type         flags;

   assign req_ready  = !busy_ff;
   assign accept     = req_valid && req_ready;
   assign active_now = req_data.frame_start || frame_active_ff;
   assign in_header  = !hpos_ff[pfu_pkg::HPOS_WIDTH-1] || req_data.frame_start;
   assign load_pixels = accept && active_now && !in_header;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign emit      = busy_ff && slot_free;
   assign done      = last_digit || flags.frame_end;

   pfu_unpack u_unpack (
      .clock       (clock),
      .reset       (reset),
      .load        (load_pixels),
      .load_byte   (req_data.data_byte),
      .depth_code  (depth_ff),
      .advance     (emit),
      .pixel_index (pixel_index),
      .last_digit  (last_digit)
   );

   pfu_raster u_raster (
      .clock       (clock),
      .reset       (reset),
      .clear       (accept && req_data.frame_start),
      .step        (emit),
      .line_pixels (line_pixels_ff),
      .frame_rows  (frame_rows_ff),
      .flags       (flags)
   );

   // Header and frame control
   always_comb begin
      frame_active_in = frame_active_ff;
      hpos_in         = hpos_ff;
      depth_in        = depth_ff;
      busy_in         = busy_ff;
      if (accept && req_data.frame_start) begin
         frame_active_in = 1'b1;
         hpos_in         = '0;
      end
      if (accept && active_now && in_header) begin
         hpos_in = (req_data.frame_start ? '0 : hpos_ff) + 6'd1;
         if (!req_data.frame_start && hpos_ff == 6'd1) begin
            depth_in = (req_data.data_byte[5:4] == pfu_pkg::DEPTH_8BPP) ?
                       pfu_pkg::DEPTH_2BPP : req_data.data_byte[5:4];
         end
      end
      if (load_pixels) begin
         busy_in = 1'b1;
      end
      if (emit && done) begin
         busy_in = 1'b0;
      end
      if (emit && flags.frame_end) begin
         frame_active_in = 1'b0;
      end
   end

   // Output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (emit) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in.pixel_argb   = pfu_pkg::grey_argb(palette_ff[pixel_index]);
         rsp_data_in.last_of_byte = done;
         rsp_data_in.line_end     = flags.line_end;
         rsp_data_in.frame_end    = flags.frame_end;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      // Even header bytes carry palette entries in their low nibble
      if (accept && active_now && in_header && (req_data.frame_start || !hpos_ff[0])) begin
         palette_ff[req_data.frame_start ? '0 : hpos_ff[pfu_pkg::PAL_IDX_WIDTH:1]] <=
            req_data.data_byte[pfu_pkg::PAL_WIDTH-1:0];
      end
      if (reset) begin
         line_pixels_ff  <= pfu_pkg::LINE_PIXELS_RESET;
         frame_rows_ff   <= pfu_pkg::FRAME_ROWS_RESET;
         frame_active_ff <= 1'b0;
         hpos_ff         <= '0;
         depth_ff        <= pfu_pkg::DEPTH_2BPP;
         busy_ff         <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               pfu_pkg::CSR_LINE_PIXELS: line_pixels_ff <= csr_write_data;
               pfu_pkg::CSR_FRAME_ROWS:  frame_rows_ff  <= csr_write_data;
               default: ;
            endcase
         end
         frame_active_ff <= frame_active_in;
         hpos_ff         <= hpos_in;
         depth_ff        <= depth_in;
         busy_ff         <= busy_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== hdl/pfu_unpack.sv =====
// ----------------------------------------------------------------------------
// pfu_unpack
// Digit-serial byte shifter: hands out one pixel index per advance, lowest bits
// first, at the digit width set by the depth code.
// ----------------------------------------------------------------------------
module pfu_unpack (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                load,
   input  logic [7:0]                          load_byte,
   input  logic [1:0]                          depth_code,
   input  logic                                advance,
   output logic [pfu_pkg::PAL_IDX_WIDTH-1:0]   pixel_index,
   output logic                                last_digit
);

   logic [7:0]                           shift_ff, shift_in;
   logic [pfu_pkg::DIGIT_CNT_WIDTH-1:0]  count_ff, count_in;
   logic [7:0]                           shifted;
   logic [pfu_pkg::DIGIT_CNT_WIDTH-1:0]  digits_per_byte;

   always_comb begin
      case (depth_code)
         pfu_pkg::DEPTH_1BPP: begin
            pixel_index     = {3'b000, shift_ff[0]};
            shifted         = {1'b0, shift_ff[7:1]};
            digits_per_byte = 4'd8;
         end
         pfu_pkg::DEPTH_4BPP: begin
            pixel_index     = shift_ff[3:0];
            shifted         = {4'b0000, shift_ff[7:4]};
            digits_per_byte = 4'd2;
         end
         default: begin
            pixel_index     = {2'b00, shift_ff[1:0]};
            shifted         = {2'b00, shift_ff[7:2]};
            digits_per_byte = 4'd4;
         end
      endcase
   end

   assign last_digit = (count_ff == 4'd1);

   always_comb begin
      shift_in = shift_ff;
      count_in = count_ff;
      if (load) begin
         shift_in = load_byte;
         count_in = digits_per_byte;
      end else if (advance) begin
         shift_in = shifted;
         count_in = count_ff - 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

// ===== hdl/pfu_raster.sv =====
// ----------------------------------------------------------------------------
// pfu_raster
// Column and row counters; flags the pixel that ends a line or the frame.
// ----------------------------------------------------------------------------
module pfu_raster (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               clear,
   input  logic                               step,
   input  logic [pfu_pkg::COUNT_WIDTH-1:0]    line_pixels,
   input  logic [pfu_pkg::COUNT_WIDTH-1:0]    frame_rows,
   output pfu_pkg::raster_flags_type          flags
);

   logic [pfu_pkg::COUNT_WIDTH-1:0] column_ff, column_in;
   logic [pfu_pkg::COUNT_WIDTH-1:0] row_ff, row_in;
   logic [pfu_pkg::COUNT_WIDTH-1:0] column_next, row_next;

   // Column steps only while column + 1 < line_pixels, so it cannot wrap
   assign column_next     = column_ff + 13'd1;
   assign row_next        = row_ff + 13'd1;
   assign flags.line_end  = (column_next >= line_pixels);
   assign flags.frame_end = flags.line_end && (row_next >= frame_rows);

   always_comb begin
      column_in = column_ff;
      row_in    = row_ff;
      if (clear) begin
         column_in = '0;
         row_in    = '0;
      end else if (step) begin
         if (flags.line_end) begin
            column_in = '0;
            row_in    = flags.frame_end ? '0 : row_next;
         end else begin
            column_in = column_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= '0;
         row_ff    <= '0;
      end else begin
         column_ff <= column_in;
         row_ff    <= row_in;
      end
   end

endmodule

// ===== hdl/pfu_checker.sv =====
// ----------------------------------------------------------------------------
// pfu_checker
// Port-level checks on the pixel unpacker, bound to the top level.
// ----------------------------------------------------------------------------
module pfu_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  pfu_pkg::req_type  req_data,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  pfu_pkg::rsp_type  rsp_data
);

   // Hold a stalled pixel transaction
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled pixel changed or dropped");

   // A frame end always closes the line and the byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.frame_end |-> rsp_data.line_end && rsp_data.last_of_byte)
      else $error("frame end without line end or last of byte");

   // A frame start byte is header, so the input is free again next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.frame_start |=> req_ready)
      else $error("input stalled after frame start");

   // Alpha is always opaque
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.pixel_argb[31:24] == 8'hFF)
      else $error("pixel alpha not opaque");

   // No pixel right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("pixel valid after reset");

endmodule

bind palettized_framebuffer_pixel_unpacker pfu_checker u_pfu_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// ===== tb/sv/palettized_framebuffer_pixel_unpacker_scoreboard.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// palettized_framebuffer_pixel_unpacker_scoreboard
// Watches the byte, pixel and register ports of the unpacker, expands every
// accepted byte into the pixels it should produce and compares each pixel
// transaction field by field against the oldest pending prediction.
// ----------------------------------------------------------------------------
module palettized_framebuffer_pixel_unpacker_scoreboard
   import pfu_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_ready,
   input  req_type                  req_data,
   input  logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  rsp_type                  rsp_data,
   input  logic                     csr_write_enable,
   input  logic [CSR_IDX_WIDTH-1:0] csr_index,
   input  logic [COUNT_WIDTH-1:0]   csr_write_data,
   output int                       error_count,
   output int                       pending_count,
   output int                       pixel_count
);

   logic [COUNT_WIDTH-1:0] line_pixels_q;
   logic [COUNT_WIDTH-1:0] frame_rows_q;
   bit                     frame_open;
   int unsigned            header_index;
   logic [PAL_WIDTH-1:0]   palette_q [PALETTE_ENTRIES];
   logic [1:0]             depth_q;
   int unsigned            column_q;
   int unsigned            row_q;
   rsp_type                expected_pixels [$];
   int                     mismatches = 0;
   int                     pixels_seen = 0;

   // Inverted grey ramp: level 0 is full brightness, level 15 is black.
   function automatic logic [31:0] shade_argb(input logic [3:0] level);
      int unsigned inv;
      inv = 15 - level;
      return 32'hFF000000 | (((32'h88 * inv) / 15) << 16)
                          | (((32'hAA * inv) / 15) << 8)
                          | ((32'h99 * inv) / 15);
   endfunction

   function automatic void expand_byte(input req_type item);
      int unsigned bpp;
      int unsigned per_byte;
      int unsigned k;
      logic [3:0]  index;
      bit          line_done;
      bit          frame_done;
      rsp_type     pix;
      if (item.frame_start) begin
         frame_open   = 1'b1;
         header_index = 0;
         column_q     = 0;
         row_q        = 0;
      end
      if (!frame_open)
         return;
      if (header_index < HEADER_BYTES) begin
         if (header_index % 2 == 0)
            palette_q[header_index / 2] = item.data_byte[3:0];
         if (header_index == 1)
            depth_q = (item.data_byte[5:4] == DEPTH_8BPP) ? DEPTH_2BPP : item.data_byte[5:4];
         header_index++;
         return;
      end
      case (depth_q)
         DEPTH_1BPP: bpp = 1;
         DEPTH_4BPP: bpp = 4;
         default:    bpp = 2;
      endcase
      per_byte = 8 / bpp;
      for (k = 0; k < per_byte; k++) begin
         index      = 4'((item.data_byte >> (k * bpp)) & ((1 << bpp) - 1));
         line_done  = 1'b0;
         frame_done = 1'b0;
         column_q++;
         if (column_q >= line_pixels_q) begin
            line_done = 1'b1;
            column_q  = 0;
            row_q++;
            if (row_q >= frame_rows_q) begin
               frame_done = 1'b1;
               frame_open = 1'b0;
               row_q      = 0;
            end
         end
         pix.pixel_argb   = shade_argb(palette_q[index]);
         pix.last_of_byte = frame_done || (k == per_byte - 1);
         pix.line_end     = line_done;
         pix.frame_end    = frame_done;
         expected_pixels.push_back(pix);
         // drop the rest of the byte once the frame is over
         if (frame_done)
            break;
      end
   endfunction

   always @(posedge clock) begin : monitor
      rsp_type seen;
      rsp_type want;
      if (reset) begin
         line_pixels_q = LINE_PIXELS_RESET;
         frame_rows_q  = FRAME_ROWS_RESET;
         frame_open    = 1'b0;
         header_index  = 0;
         depth_q       = DEPTH_2BPP;
         column_q      = 0;
         row_q         = 0;
         foreach (palette_q[i])
            palette_q[i] = '0;
         expected_pixels.delete();
      end else begin
         if (csr_write_enable) begin
            if (csr_index == CSR_LINE_PIXELS)
               line_pixels_q = csr_write_data;
            else if (csr_index == CSR_FRAME_ROWS)
               frame_rows_q = csr_write_data;
         end
         if (req_valid && req_ready)
            expand_byte(req_data);
         if (rsp_valid && rsp_ready) begin
            seen = rsp_data;
            pixels_seen++;
            if (expected_pixels.size() == 0) begin
               $error("unexpected pixel transaction: pixel_argb %h", seen.pixel_argb);
               mismatches++;
            end else begin
               want = expected_pixels.pop_front();
               if (seen.pixel_argb !== want.pixel_argb) begin
                  $error("pixel_argb: expected %h, got %h", want.pixel_argb, seen.pixel_argb);
                  mismatches++;
               end
               if (seen.last_of_byte !== want.last_of_byte) begin
                  $error("last_of_byte: expected %b, got %b",
                         want.last_of_byte, seen.last_of_byte);
                  mismatches++;
               end
               if (seen.line_end !== want.line_end) begin
                  $error("line_end: expected %b, got %b", want.line_end, seen.line_end);
                  mismatches++;
               end
               if (seen.frame_end !== want.frame_end) begin
                  $error("frame_end: expected %b, got %b", want.frame_end, seen.frame_end);
                  mismatches++;
               end
            end
         end
      end
      error_count   <= mismatches;
      pending_count <= expected_pixels.size();
      pixel_count   <= pixels_seen;
   end

endmodule

// ===== tb/sv/palettized_framebuffer_pixel_unpacker_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// palettized_framebuffer_pixel_unpacker_tb
// Feeds framebuffer headers and packed pixel bytes into the unpacker under
// changing line and frame sizes, with random sender and receiver stalls, and
// reports the verdict from the scoreboard's mismatch and pending counts.
// ----------------------------------------------------------------------------
module palettized_framebuffer_pixel_unpacker_tb;
   import pfu_pkg::*;

   localparam int IDLE_GUARD   = 12;
   localparam int HOLD_CYCLES  = 300;
   localparam int STALL_LIMIT  = 5000;
   localparam int RANDOM_BYTES = 24;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   req_type                  req_data;
   logic                     rsp_valid;
   logic                     rsp_ready;
   rsp_type                  rsp_data;
   logic                     csr_write_enable;
   logic [CSR_IDX_WIDTH-1:0] csr_index;
   logic [COUNT_WIDTH-1:0]   csr_write_data;

   int                       error_count;
   int                       pending_count;
   int                       pixel_count;
   int                       bytes_sent;
   int                       frames_started;
   int                       pixel_bytes;
   int                       send_idle_pct;
   int                       recv_idle_pct;
   int                       quiet_cycles = 0;
   logic                     hold_request;

   palettized_framebuffer_pixel_unpacker DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   palettized_framebuffer_pixel_unpacker_scoreboard pixel_scoreboard (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .error_count      (error_count),
      .pending_count    (pending_count),
      .pixel_count      (pixel_count)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Pixel receiver: random stalls, or one long hold-off on request.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_write_enable)
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic send_item(input logic [7:0] value, input logic start);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= {value, start};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      bytes_sent++;
   endtask

   // Hold the sender until every predicted pixel is out and the block is idle.
   task automatic pause_and_drain();
      req_valid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (IDLE_GUARD) @(negedge clock);
   endtask

   task automatic set_config(input logic [COUNT_WIDTH-1:0] line_pixels,
                             input logic [COUNT_WIDTH-1:0] frame_rows);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_LINE_PIXELS;
      csr_write_data   <= line_pixels;
      @(negedge clock);
      csr_index        <= CSR_FRAME_ROWS;
      csr_write_data   <= frame_rows;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Entry i of the palette sits in pal_bits[4*i +: 4].
   task automatic send_header(input logic [1:0] depth, input logic [63:0] pal_bits,
                              input int count);
      logic [7:0] b;
      int         i;
      for (i = 0; i < count; i++) begin
         b = 8'($urandom_range(0, 255));
         if (i % 2 == 0)
            b[3:0] = pal_bits[(i / 2) * 4 +: 4];
         if (i == 1)
            b[5:4] = depth;
         send_item(b, i == 0);
      end
      if (count > 0)
         frames_started++;
   endtask

   task automatic send_pixels(input int count);
      repeat (count) begin
         send_item(8'($urandom_range(0, 255)), 1'b0);
         pixel_bytes++;
      end
   endtask

   initial begin : stimulus
      int                     mode;
      logic [COUNT_WIDTH-1:0] line_pixels;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_data         = '0;
      csr_write_enable = 1'b0;
      csr_index        = CSR_LINE_PIXELS;
      csr_write_data   = '0;
      hold_request     = 1'b0;
      send_idle_pct    = 30;
      recv_idle_pct    = 56;
      bytes_sent       = 0;
      frames_started   = 0;
      pixel_bytes      = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // no frame open yet: these bytes are dropped
      send_item(8'hFF, 1'b0);
      send_item(8'h00, 1'b0);
      // zero rows: the frame ends with the first line, the next byte is dropped
      pause_and_drain();
      set_config(13'd8, 13'd0);
      send_header(DEPTH_1BPP, 64'hFEDCBA9876543210, 32);
      send_item(8'h5A, 1'b0);
      send_item(8'hFF, 1'b0);
      // 8 bpp fallback, frame left open after a few pixels
      pause_and_drain();
      set_config(13'd5, 13'd2);
      send_header(DEPTH_8BPP, 64'h0123456789ABCDEF, 32);
      send_item(8'hE4, 1'b0);
      // restart mid-frame with a header cut short, then a full one;
      // the line and the frame end mid-byte
      send_header(DEPTH_2BPP, 64'hFEDCBA9876543210, 4);
      send_header(DEPTH_2BPP, 64'h0123456789ABCDEF, 32);
      send_item(8'hE4, 1'b0);
      send_item(8'h1B, 1'b0);
      send_item(8'h55, 1'b0);
      // one pixel per line, then walk all sixteen grey levels at 4 bpp
      pause_and_drain();
      set_config(13'd0, 13'd4095);
      send_header(DEPTH_4BPP, 64'hFEDCBA9876543210, 32);
      send_item(8'h10, 1'b0);
      send_item(8'h32, 1'b0);
      send_item(8'h54, 1'b0);
      send_item(8'h76, 1'b0);
      send_item(8'h98, 1'b0);
      send_item(8'hBA, 1'b0);
      send_item(8'hDC, 1'b0);
      send_item(8'hFE, 1'b0);

      // random pixel bytes in the open frame, new line length per phase
      for (mode = 0; mode < 3; mode++) begin
         case (mode)
            0: begin
               send_idle_pct = 30;
               recv_idle_pct = 56;
            end
            1: begin
               send_idle_pct = 56;
               recv_idle_pct = 30;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         pause_and_drain();
         if ($urandom_range(3) == 0)
            line_pixels = 13'($urandom_range(0, 15));
         else
            line_pixels = 13'(8 * $urandom_range(1, 4));
         set_config(line_pixels, 13'd4095);
         // long receiver hold-off while bytes keep coming
         if (mode == 2)
            hold_request <= 1'b1;
         send_pixels(RANDOM_BYTES / 3);
      end
      pause_and_drain();

      if (pending_count != 0)
         $error("%0d predicted pixels never arrived", pending_count);
      $display("Sent %0d framebuffer bytes (%0d random pixel bytes) over %0d frame starts",
               bytes_sent, pixel_bytes, frames_started);
      $display("and checked %0d pixels: 1, 2 and 4 bpp, the 8 bpp fallback, restarts,",
               pixel_count);
      $display("odd and zero line sizes, zero rows, dropped bytes and a long output hold-off.");
      if (error_count == 0 && pending_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
